>>> src/cfsp_pkg.sv
package cfsp_pkg;

    // pool geometry
    localparam int CHUNK_STRIDE = 64;
    localparam int MAX_CHUNKS   = 16;
    localparam int POOL_SLOTS   = 1024;
    localparam int LIST_END     = 1024;
    localparam int COUNT_MAX    = 2047;

    // field widths
    localparam int SLOT_W   = 10;
    localparam int LINK_W   = 11;
    localparam int COUNT_W  = 11;
    localparam int SPC_W    = 7;
    localparam int MAXC_W   = 5;
    localparam int ACT_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 7;

    // derived widths
    localparam int GROWN_W = $clog2(MAX_CHUNKS + 1);
    localparam int CIDX_W  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int N_W     = $clog2(CHUNK_STRIDE + 1);
    localparam int SUM_W   = $clog2(MAX_CHUNKS * CHUNK_STRIDE + CHUNK_STRIDE) + 1;

    // stream widths
    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = ACT_W;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 1;
    localparam int OUT_PAD_W   = OUT_TDATA_W - SLOT_W - COUNT_W;

    // register reset values
    localparam int SPC_RESET  = 64;
    localparam int MAXC_RESET = 16;

    typedef logic [ACT_W-1:0] action_t;
    localparam action_t ACT_ALLOC = 2'd0;
    localparam action_t ACT_FREE  = 2'd1;
    localparam action_t ACT_RESET = 2'd2;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;
    localparam cfg_index_t CFG_SLOTS_PER_CHUNK = 1'b0;
    localparam cfg_index_t CFG_MAX_CHUNKS      = 1'b1;

endpackage

>>> src/chunked_free_list_slot_pool.sv
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tuser: action; tdata: slot
// m_*       out  m_tvalid/m_tready  tuser: status; tdata: granted_slot, slots_in_use
// cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data (slots_per_chunk, max_chunks)
//
// alloc from a non-empty list: one link read; free: one link write; exhausted alloc: no link access
// alloc that grows a chunk: n pushes, n = clamped slots_per_chunk (one push a cycle), then a read and pop
// reset pool: one link write a cycle for every slot of all grown chunks
// the link memory has a single write port and a single read port
// rst_n clears state, head, chunk and in-use counts, config, m_tvalid; payload regs and link memory are not cleared
// a result held on m_* does not block acceptance; finishing the next item waits for it
module chunked_free_list_slot_pool
    import cfsp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [9:0] slot
    input  logic [IN_TUSER_W-1:0]  s_tuser,   // [1:0] action
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [9:0] granted_slot, [20:10] slots_in_use
    output logic [OUT_TUSER_W-1:0] m_tuser,   // [0] status
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_WALK = 6'b000010,
        ST_RD   = 6'b000100,
        ST_POP  = 6'b001000,
        ST_FREE = 6'b010000,
        ST_FIN  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // free list state
    logic [LINK_W-1:0]  head_reg, head_next;
    logic [GROWN_W-1:0] grown_reg, grown_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [N_W-1:0]     chunk_n_reg [MAX_CHUNKS];

    // configuration
    logic [SPC_W-1:0]  spc_reg;
    logic [MAXC_W-1:0] maxc_reg;

    // slot walker shared by grow and reset pool
    logic [CIDX_W-1:0] walk_c_reg, walk_c_next;
    logic [N_W-1:0]    walk_i_reg, walk_i_next;
    logic              walk_grow_reg, walk_grow_next;

    // held item fields
    logic [SLOT_W-1:0] slot_in_reg, slot_in_next;
    logic              res_status_reg, res_status_next;

    // output register
    logic               m_valid_reg, m_valid_next;
    logic [SLOT_W-1:0]  m_granted_reg, m_granted_next;
    logic               m_status_reg, m_status_next;
    logic [COUNT_W-1:0] m_count_reg, m_count_next;

    // link memory port
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [LINK_W-1:0] ram_wdata;
    logic              ram_re;
    logic [SLOT_W-1:0] ram_raddr;
    logic [LINK_W-1:0] ram_rdata;

    logic              s_accept;
    logic              out_free;
    logic              list_empty;
    logic [N_W-1:0]    spc_eff;
    logic [N_W-1:0]    walk_n;
    logic [SUM_W-1:0]  walk_slot;
    logic              walk_in_pool;
    logic              chunk_end;
    logic [SUM_W-1:0]  grow_base;
    logic              grow_ok;
    logic              chunk_wr;
    logic [COUNT_W-1:0] count_inc;
    logic [COUNT_W-1:0] count_dec;
    logic [GROWN_W-1:0] grown_last;

    cfsp_ram #(
        .WIDTH (LINK_W),
        .DEPTH (POOL_SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign list_empty = (head_reg >= LINK_W'(LIST_END));

    // slots per grow, clamped to 1..stride
    always_comb
    begin
        if (spc_reg == '0)
        begin
            spc_eff = N_W'(1);
        end
        else if (int'(spc_reg) > CHUNK_STRIDE)
        begin
            spc_eff = N_W'(CHUNK_STRIDE);
        end
        else
        begin
            spc_eff = N_W'(spc_reg);
        end
    end

    // grow needs room under both limits and a base inside the pool
    assign grow_base = SUM_W'(grown_reg) * SUM_W'(CHUNK_STRIDE);
    assign grow_ok   = (grown_reg < GROWN_W'(maxc_reg))
                    && (grown_reg < GROWN_W'(MAX_CHUNKS))
                    && (grow_base < SUM_W'(POOL_SLOTS));
    assign grown_last = grown_reg - GROWN_W'(1);

    // walker slot = chunk * stride + i
    assign walk_n       = chunk_n_reg[walk_c_reg];
    assign walk_slot    = SUM_W'(walk_c_reg) * SUM_W'(CHUNK_STRIDE) + SUM_W'(walk_i_reg);
    assign walk_in_pool = (walk_slot < SUM_W'(POOL_SLOTS));
    assign chunk_end    = !walk_in_pool || ((walk_i_reg + N_W'(1)) == walk_n);

    // in-use count saturates at both ends
    assign count_inc = (count_reg < COUNT_W'(COUNT_MAX)) ? count_reg + COUNT_W'(1) : count_reg;
    assign count_dec = (count_reg != '0) ? count_reg - COUNT_W'(1) : count_reg;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        grown_next      = grown_reg;
        count_next      = count_reg;
        walk_c_next     = walk_c_reg;
        walk_i_next     = walk_i_reg;
        walk_grow_next  = walk_grow_reg;
        slot_in_next    = slot_in_reg;
        res_status_next = res_status_reg;
        chunk_wr        = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = walk_slot[SLOT_W-1:0];
        ram_wdata       = head_reg;
        ram_re          = 1'b0;
        ram_raddr       = head_reg[SLOT_W-1:0];
        m_valid_next    = m_valid_reg && !m_tready;
        m_granted_next  = m_granted_reg;
        m_status_next   = m_status_reg;
        m_count_next    = m_count_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    case (action_t'(s_tuser))
                        ACT_ALLOC:
                        begin
                            if (!list_empty)
                            begin
                                ram_re     = 1'b1;
                                state_next = ST_POP;
                            end
                            else if (grow_ok)
                            begin
                                chunk_wr       = 1'b1;
                                grown_next     = grown_reg + GROWN_W'(1);
                                walk_c_next    = grown_reg[CIDX_W-1:0];
                                walk_i_next    = '0;
                                walk_grow_next = 1'b1;
                                state_next     = ST_WALK;
                            end
                            else
                            begin
                                res_status_next = 1'b1;
                                state_next      = ST_FIN;
                            end
                        end
                        ACT_FREE:
                        begin
                            slot_in_next = s_tdata[SLOT_W-1:0];
                            state_next   = ST_FREE;
                        end
                        ACT_RESET:
                        begin
                            head_next       = LINK_W'(LIST_END);
                            count_next      = '0;
                            res_status_next = 1'b0;
                            if (grown_reg == '0)
                            begin
                                state_next = ST_FIN;
                            end
                            else
                            begin
                                // newest chunk first
                                walk_c_next    = grown_last[CIDX_W-1:0];
                                walk_i_next    = '0;
                                walk_grow_next = 1'b0;
                                state_next     = ST_WALK;
                            end
                        end
                        default:
                        begin
                            res_status_next = 1'b0;
                            state_next      = ST_FIN;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                if (walk_in_pool)
                begin
                    ram_we    = 1'b1;
                    head_next = LINK_W'(walk_slot);
                end
                if (chunk_end)
                begin
                    if (walk_grow_reg)
                    begin
                        state_next = ST_RD;
                    end
                    else if (walk_c_reg == '0)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        walk_c_next = walk_c_reg - CIDX_W'(1);
                        walk_i_next = '0;
                    end
                end
                else
                begin
                    walk_i_next = walk_i_reg + N_W'(1);
                end
            end
            ST_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_POP;
            end
            ST_POP:
            begin
                if (out_free)
                begin
                    head_next      = ram_rdata;
                    count_next     = count_inc;
                    m_valid_next   = 1'b1;
                    m_granted_next = head_reg[SLOT_W-1:0];
                    m_status_next  = 1'b0;
                    m_count_next   = count_inc;
                    state_next     = ST_IDLE;
                end
            end
            ST_FREE:
            begin
                if (out_free)
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = slot_in_reg;
                    head_next      = LINK_W'(slot_in_reg);
                    count_next     = count_dec;
                    m_valid_next   = 1'b1;
                    m_granted_next = '0;
                    m_status_next  = 1'b0;
                    m_count_next   = count_dec;
                    state_next     = ST_IDLE;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    m_valid_next   = 1'b1;
                    m_granted_next = '0;
                    m_status_next  = res_status_reg;
                    m_count_next   = count_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            head_reg    <= LINK_W'(LIST_END);
            grown_reg   <= '0;
            count_reg   <= '0;
            spc_reg     <= SPC_W'(SPC_RESET);
            maxc_reg    <= MAXC_W'(MAXC_RESET);
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            grown_reg   <= grown_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_SLOTS_PER_CHUNK:
                    begin
                        spc_reg <= cfg_data[SPC_W-1:0];
                    end
                    CFG_MAX_CHUNKS:
                    begin
                        maxc_reg <= cfg_data[MAXC_W-1:0];
                    end
                    default:
                    begin
                        spc_reg <= spc_reg;
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        walk_c_reg     <= walk_c_next;
        walk_i_reg     <= walk_i_next;
        walk_grow_reg  <= walk_grow_next;
        slot_in_reg    <= slot_in_next;
        res_status_reg <= res_status_next;
        m_granted_reg  <= m_granted_next;
        m_status_reg   <= m_status_next;
        m_count_reg    <= m_count_next;
        if (chunk_wr)
        begin
            chunk_n_reg[grown_reg[CIDX_W-1:0]] <= spc_eff;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, m_count_reg, m_granted_reg};
    assign m_tuser  = m_status_reg;

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |-> (head_reg < LINK_W'(LIST_END)))
        else $error("pop from an empty free list");

    a_grow_leaves_head: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD) |-> (head_reg < LINK_W'(LIST_END)))
        else $error("grow pushed no slot");

    a_fail_zero_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[SLOT_W-1:0] == '0))
        else $error("failed alloc carries a slot");

    a_grown_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && walk_grow_reg) |-> (grown_reg <= GROWN_W'(MAX_CHUNKS)))
        else $error("chunk count beyond limit");
`endif

endmodule

>>> src/cfsp_ram.sv
module cfsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
